@@ hdl/selective_repeat_sender_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the selective-repeat sender
// Short forms of a clocked concurrent assertion that reports by $error.
// ----------------------------------------------------------------------------
`ifndef SELECTIVE_REPEAT_SENDER_MACROS_SVH
`define SELECTIVE_REPEAT_SENDER_MACROS_SVH

// Checked only while reset is released.
`define SRS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define SRS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/srs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srs_pkg
// Shared types and constants of the selective-repeat sender.
// ----------------------------------------------------------------------------
package srs_pkg;

	localparam int MAX_SEQ    = 256;
	localparam int MAX_WINDOW = 16;

	localparam int SEQ_W   = $clog2(MAX_SEQ);      // slot address width
	localparam int CNT_W   = SEQ_W + 1;            // holds MAX_SEQ itself
	localparam int WIN_W   = 5;                    // window register width
	localparam int BYTE_W  = 8;
	localparam int LIMIT_W = CNT_W + 1;

	localparam logic [1:0] OP_LOAD    = 2'd0;
	localparam logic [1:0] OP_START   = 2'd1;
	localparam logic [1:0] OP_ACK     = 2'd2;
	localparam logic [1:0] OP_TIMEOUT = 2'd3;

	localparam logic REG_FRAME_COUNT = 1'b0;
	localparam logic REG_WIN_LEN     = 1'b1;

	localparam logic KIND_FRAME  = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// One request to the payload store: an optional write and a read.
	typedef struct packed {
		logic              wr_en;
		logic [SEQ_W-1:0]  wr_addr;
		logic [BYTE_W-1:0] wr_data;
		logic [SEQ_W-1:0]  rd_addr;
	} mem_req_t;

endpackage

@@ hdl/srs_payload_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srs_payload_mem
// Payload store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module srs_payload_mem
	import srs_pkg::*;
(
	input  logic              clk,
	input  mem_req_t          req,
	output logic [BYTE_W-1:0] rd_data
);

	logic [BYTE_W-1:0] mem_q [MAX_SEQ];
	logic [BYTE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
		rd_data_q <= mem_q[req.rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

@@ hdl/selective_repeat_sender.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// selective_repeat_sender
// Sender side of a selective-repeat ARQ link: payload store, acknowledge
// flags, window base and send pointer, walked by a small sequencer.
// ----------------------------------------------------------------------------
//
//   channel   handshake              words
//   -------   ---------------------  -----------------------------------------
//   command   start / busy           operation, index, payload_byte
//   config    wr_en                  wr_index, wr_data
//   result    strobe (no stall)      kind, seq_no, payload, is_eof,
//                                    window_base, all_done, last
//
// A command word is taken at a clock edge with start high and busy low; a load
// writes the store at that edge and shows its status word in the next cycle.
// The acknowledge flags live in a 256-entry memory with registered reads, so
// each flag test is a read state followed by a test state. Reset and every
// start run a clearing pass over all the flags while busy is high. An
// acknowledge slides the base one acknowledged frame per read and test, then
// stops and hands over to the scan. The scan visits each slot of the window
// (at most 16), first moves the send pointer up to the base if it has fallen
// behind, and closes with the status word. Results cannot be held off by the
// receiver.
// ----------------------------------------------------------------------------
module selective_repeat_sender
	import srs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// command channel
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        operation,
	input  logic [SEQ_W-1:0]  index,
	input  logic [BYTE_W-1:0] payload_byte,
	// configuration write port
	input  logic              wr_en,
	input  logic              wr_index,
	input  logic [CNT_W-1:0]  wr_data,
	// result channel
	output logic              strobe,
	output logic              kind,
	output logic [SEQ_W-1:0]  seq_no,
	output logic [BYTE_W-1:0] payload,
	output logic              is_eof,
	output logic [CNT_W-1:0]  window_base,
	output logic              all_done,
	output logic              last
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SLIDE_RD,
		ST_SLIDE,
		ST_SEND_RD,
		ST_SEND
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    frame_count_q;
	logic [WIN_W-1:0]    win_len_q;
	logic [CNT_W-1:0]    base_q;
	logic [CNT_W-1:0]    send_q;
	logic [SEQ_W-1:0]    clr_q;
	logic                clr_send_q;

	// Acknowledge flags, one per sequence number, with a registered read.
	logic                ack_mem_q [MAX_SEQ];
	logic                ack_rd_q;
	logic                ack_wr_en;
	logic [SEQ_W-1:0]    ack_wr_addr;
	logic                ack_wr_data;
	logic [SEQ_W-1:0]    ack_rd_addr;

	// Output stage: the word waiting for the payload read to land.
	logic                valid_s1;
	logic                kind_s1;
	logic [SEQ_W-1:0]    seq_s1;
	logic                eof_s1;

	logic [CNT_W-1:0]    eff_count;
	logic [WIN_W-1:0]    eff_window;
	logic [LIMIT_W-1:0]  limit;
	logic                accept;
	logic                base_can_slide;
	logic                send_in_window;
	logic                send_is_last;
	mem_req_t            mem_req;
	logic [BYTE_W-1:0]   mem_rd_data;

	// Out-of-range configuration values are clamped here, once, so the
	// sequencer only ever sees legal counts and window sizes.
	always_comb begin
		if (frame_count_q > CNT_W'(MAX_SEQ)) begin
			eff_count = CNT_W'(MAX_SEQ);
		end else begin
			eff_count = frame_count_q;
		end
		if (win_len_q == '0) begin
			eff_window = WIN_W'(1);
		end else if (win_len_q > WIN_W'(MAX_WINDOW)) begin
			eff_window = WIN_W'(MAX_WINDOW);
		end else begin
			eff_window = win_len_q;
		end
	end

	assign accept = start && !busy;
	assign limit  = LIMIT_W'(base_q) + LIMIT_W'(eff_window);

	// The base can move while it is inside the transfer and its flag, read
	// in the cycle before, is set. The flag is only trusted below the frame
	// count, so the low bits of the base always name a real slot.
	assign base_can_slide = (base_q < eff_count) && ack_rd_q;

	// The send pointer has frames left to look at in this window.
	assign send_in_window = (LIMIT_W'(send_q) < limit) && (send_q < eff_count);
	assign send_is_last   = (LIMIT_W'(send_q) + LIMIT_W'(1)) == LIMIT_W'(eff_count);

	// The clearing pass owns the flag write port while it runs; otherwise an
	// accepted acknowledge sets its flag at the accepting edge.
	always_comb begin
		ack_wr_en   = 1'b0;
		ack_wr_addr = index;
		ack_wr_data = 1'b1;
		if (state_q == ST_CLEAR) begin
			ack_wr_en   = 1'b1;
			ack_wr_addr = clr_q;
			ack_wr_data = 1'b0;
		end else if (accept && (operation == OP_ACK)) begin
			ack_wr_en = 1'b1;
		end
	end

	// The slide looks at the flag under the base, the scan at the one under
	// the send pointer.
	assign ack_rd_addr = ((state_q == ST_SLIDE_RD) || (state_q == ST_SLIDE)) ?
	                     base_q[SEQ_W-1:0] : send_q[SEQ_W-1:0];

	always_ff @(posedge clk) begin
		if (ack_wr_en) begin
			ack_mem_q[ack_wr_addr] <= ack_wr_data;
		end
		ack_rd_q <= ack_mem_q[ack_rd_addr];
	end

	// A load writes the store; the scan reads the slot under the send
	// pointer every cycle, and the data arrives with the output stage.
	always_comb begin
		mem_req.wr_en   = accept && (operation == OP_LOAD);
		mem_req.wr_addr = index;
		mem_req.wr_data = payload_byte;
		mem_req.rd_addr = send_q[SEQ_W-1:0];
	end

	srs_payload_mem u_mem (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (mem_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			frame_count_q <= CNT_W'(26);
			win_len_q     <= WIN_W'(4);
			base_q        <= '0;
			send_q        <= '0;
			clr_q         <= '0;
			clr_send_q    <= 1'b0;
			valid_s1      <= 1'b0;
			kind_s1       <= KIND_FRAME;
			seq_s1        <= '0;
			eof_s1        <= 1'b0;
		end else begin
			valid_s1 <= 1'b0;

			if (wr_en) begin
				unique case (wr_index)
					REG_FRAME_COUNT: frame_count_q <= wr_data;
					REG_WIN_LEN:     win_len_q     <= wr_data[WIN_W-1:0];
					default: ;
				endcase
			end

			unique case (state_q)
				ST_CLEAR: begin
					// One flag is cleared per cycle. After reset the block goes
					// idle; after a start the scan follows.
					clr_q <= clr_q + SEQ_W'(1);
					if (clr_q == '1) begin
						state_q <= clr_send_q ? ST_SEND_RD : ST_IDLE;
					end
				end

				ST_IDLE: begin
					if (accept) begin
						unique case (operation)
							OP_LOAD: begin
								// Store write happens in the memory; only the
								// status word follows.
								valid_s1 <= 1'b1;
								kind_s1  <= KIND_STATUS;
								seq_s1   <= '0;
								eof_s1   <= 1'b0;
							end
							OP_START: begin
								base_q     <= '0;
								send_q     <= '0;
								clr_q      <= '0;
								clr_send_q <= 1'b1;
								state_q    <= ST_CLEAR;
							end
							OP_ACK: begin
								state_q <= ST_SLIDE_RD;
							end
							OP_TIMEOUT: begin
								send_q  <= base_q;
								state_q <= ST_SEND_RD;
							end
							default: ;
						endcase
					end
				end

				ST_SLIDE_RD: begin
					state_q <= ST_SLIDE;
				end

				ST_SLIDE: begin
					// One acknowledged frame is passed per read.
					if (base_can_slide) begin
						base_q  <= base_q + CNT_W'(1);
						state_q <= ST_SLIDE_RD;
					end else begin
						state_q <= ST_SEND_RD;
					end
				end

				ST_SEND_RD: begin
					state_q <= ST_SEND;
				end

				ST_SEND: begin
					if (send_q < base_q) begin
						// Everything below the base is acknowledged already.
						send_q  <= base_q;
						state_q <= ST_SEND_RD;
					end else if (send_in_window) begin
						if (!ack_rd_q) begin
							valid_s1 <= 1'b1;
							kind_s1  <= KIND_FRAME;
							seq_s1   <= send_q[SEQ_W-1:0];
							eof_s1   <= send_is_last;
						end
						send_q  <= send_q + CNT_W'(1);
						state_q <= ST_SEND_RD;
					end else begin
						valid_s1 <= 1'b1;
						kind_s1  <= KIND_STATUS;
						seq_s1   <= '0;
						eof_s1   <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// The block stays busy until the status word has been shown.
	assign busy = (state_q != ST_IDLE) || valid_s1;

	// The base does not move while words are being emitted, so every word
	// of one command carries the same base and completion flag.
	assign strobe      = valid_s1;
	assign kind        = kind_s1;
	assign seq_no      = seq_s1;
	assign payload     = (kind_s1 == KIND_STATUS) ? '0 : mem_rd_data;
	assign is_eof      = eof_s1;
	assign window_base = base_q;
	assign all_done    = base_q >= eff_count;
	assign last        = (kind_s1 == KIND_STATUS);

endmodule

@@ hdl/srs_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srs_checker
// Port-level checks of the selective-repeat sender, bound to the top level.
// ----------------------------------------------------------------------------
`include "selective_repeat_sender_macros.svh"

module srs_checker
	import srs_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              strobe,
	input logic              kind,
	input logic [SEQ_W-1:0]  seq_no,
	input logic [CNT_W-1:0]  window_base,
	input logic              all_done,
	input logic              last
);

	// A command word always keeps the block busy for the next cycle.
	`SRS_ASSERT(a_busy_after_accept, (start && !busy) |=> busy, "not busy after accepting a command")

	// The status word ends a command and is followed by a quiet cycle.
	`SRS_ASSERT(a_quiet_after_status, (strobe && last) |=> !strobe, "word right after status")

	// Only the status word is marked last.
	`SRS_ASSERT_ALWAYS(a_last_is_status, strobe |-> (last == (kind == KIND_STATUS)), "last does not match kind")

	// A frame is only sent while the transfer is open, at or above the base.
	`SRS_ASSERT(a_frame_in_window, (strobe && kind == KIND_FRAME) |-> (!all_done && ({1'b0, seq_no} >= window_base)), "frame outside the open window")

endmodule

bind selective_repeat_sender srs_checker u_srs_checker (.*);

@@ test/selective_repeat_sender_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// selective_repeat_sender_tb
// Self-checking bench for the selective-repeat ARQ sender. A behavioral copy
// of the window logic predicts every frame and status word of each command.
// A monitor compares each strobed word, field by field, with the oldest
// prediction. A short directed sequence runs first, then random traffic over
// several window settings and idling patterns.
// ----------------------------------------------------------------------------
module selective_repeat_sender_tb;
	import srs_pkg::*;

	// One word of the result channel, in port order.
	typedef struct packed {
		logic              kind;
		logic [SEQ_W-1:0]  seq;
		logic [BYTE_W-1:0] pay;
		logic              eof;
		logic [CNT_W-1:0]  base;
		logic              done;
		logic              last;
	} arq_word_t;

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              start        = 1'b0;
	logic [1:0]        operation    = OP_LOAD;
	logic [SEQ_W-1:0]  index        = '0;
	logic [BYTE_W-1:0] payload_byte = '0;
	logic              wr_en        = 1'b0;
	logic              wr_index     = REG_FRAME_COUNT;
	logic [CNT_W-1:0]  wr_data      = '0;
	logic              busy;
	logic              strobe;
	logic              kind;
	logic [SEQ_W-1:0]  seq_no;
	logic [BYTE_W-1:0] payload;
	logic              is_eof;
	logic [CNT_W-1:0]  window_base;
	logic              all_done;
	logic              last;

	selective_repeat_sender DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.operation    (operation),
		.index        (index),
		.payload_byte (payload_byte),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.strobe       (strobe),
		.kind         (kind),
		.seq_no       (seq_no),
		.payload      (payload),
		.is_eof       (is_eof),
		.window_base  (window_base),
		.all_done     (all_done),
		.last         (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copy of the sender: the payload store, the acknowledge flags,
	// both window pointers and the two configuration registers.
	logic [BYTE_W-1:0] pay_mem [MAX_SEQ];
	bit                acked   [MAX_SEQ];
	// Slots that have been loaded at least once. Frames are never allowed to
	// read a slot that is still unwritten.
	bit                loaded  [MAX_SEQ];
	int                win_base    = 0;
	int                next_send   = 0;
	int                frame_total = 26;
	int                win_setting = 4;

	// Frame and status words that the sender still owes us, oldest first.
	arq_word_t words_due [$];
	int        mismatches = 0;
	// Percentage of command slots in which the command side sits idle.
	int        idle_pct   = 0;

	// Frame count as the sender uses it: anything above MAX_SEQ is MAX_SEQ.
	function automatic int live_count();
		return (frame_total > MAX_SEQ) ? MAX_SEQ : frame_total;
	endfunction

	// Window as the sender uses it: zero acts as one, large values clamp.
	function automatic int live_window();
		if (win_setting == 0)
			return 1;
		return (win_setting > MAX_WINDOW) ? MAX_WINDOW : win_setting;
	endfunction

	// Upper bound (exclusive) of the slots a command may transmit from. The
	// acknowledge case looks ahead at how far the base will slide.
	function automatic int slots_needed(logic [1:0] op, logic [SEQ_W-1:0] idx);
		int cnt;
		int b;
		int hi;
		cnt = live_count();
		b = (op == OP_START) ? 0 : win_base;
		if (op == OP_ACK) begin
			while (b < cnt && (acked[b] || b == idx))
				b++;
		end
		hi = b + live_window();
		return (hi > cnt) ? cnt : hi;
	endfunction

	// Applies one accepted command to the shadow state and queues the words
	// it causes: the frames of the window scan, then the status word.
	task automatic advance_window(logic [1:0] op, logic [SEQ_W-1:0] idx,
	                              logic [BYTE_W-1:0] data_b);
		arq_word_t batch [$];
		arq_word_t w;
		int        cnt;
		int        lim;
		cnt = live_count();
		case (op)
			OP_LOAD: begin
				pay_mem[idx] = data_b;
				loaded[idx]  = 1'b1;
			end
			OP_START: begin
				foreach (acked[i])
					acked[i] = 1'b0;
				win_base  = 0;
				next_send = 0;
			end
			OP_ACK: begin
				acked[idx] = 1'b1;
				while (win_base < cnt && acked[win_base])
					win_base++;
			end
			default: begin
				next_send = win_base;
			end
		endcase
		if (op != OP_LOAD) begin
			// A send pointer left behind the base only skips acknowledged frames.
			if (next_send < win_base)
				next_send = win_base;
			lim = win_base + live_window();
			while (next_send < lim && next_send < cnt) begin
				if (!acked[next_send]) begin
					w      = '0;
					w.kind = KIND_FRAME;
					w.seq  = next_send[SEQ_W-1:0];
					w.pay  = pay_mem[next_send];
					w.eof  = (next_send + 1 == cnt);
					batch.push_back(w);
				end
				next_send++;
			end
		end
		w      = '0;
		w.kind = KIND_STATUS;
		w.last = 1'b1;
		batch.push_back(w);
		// Every word of the command reports the base and done state at its end.
		foreach (batch[k]) begin
			batch[k].base = win_base[CNT_W-1:0];
			batch[k].done = (win_base >= cnt);
			words_due.push_back(batch[k]);
		end
	endtask

	// Presents one command word and holds it until the sender takes it. The
	// start line stays high on return so back-to-back words need no gap.
	task automatic push_item(logic [1:0] op, logic [SEQ_W-1:0] idx,
	                         logic [BYTE_W-1:0] data_b);
		int gap;
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			// Mostly short gaps, now and then one long enough to span a scan.
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 24) : $urandom_range(1, 3);
			if (start)
				start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start        <= 1'b1;
		operation    <= op;
		index        <= idx;
		payload_byte <= data_b;
		do
			@(posedge clk);
		while (busy);
		advance_window(op, idx, data_b);
	endtask

	// Sends a command, first loading any slot the command could transmit from
	// that has never been written.
	task automatic issue(logic [1:0] op, logic [SEQ_W-1:0] idx,
	                     logic [BYTE_W-1:0] data_b);
		int hi;
		if (op != OP_LOAD) begin
			hi = slots_needed(op, idx);
			for (int i = 0; i < hi; i++)
				if (!loaded[i])
					push_item(OP_LOAD, i[SEQ_W-1:0], BYTE_W'($urandom_range(0, 255)));
		end
		push_item(op, idx, data_b);
	endtask

	// Drops start and waits until every owed word has arrived and the
	// sender has gone idle.
	task automatic settle();
		if (start)
			start <= 1'b0;
		do
			@(posedge clk);
		while (words_due.size() != 0 || busy);
	endtask

	// Configuration writes happen only while the sender is idle.
	task automatic write_reg(logic reg_sel, int value);
		settle();
		wr_en    <= 1'b1;
		wr_index <= reg_sel;
		wr_data  <= value[CNT_W-1:0];
		@(posedge clk);
		wr_en <= 1'b0;
		if (reg_sel == REG_FRAME_COUNT)
			frame_total = value & 9'h1FF;
		else
			win_setting = value & 5'h1F;
	endtask

	function automatic void compare_field(string name, logic [CNT_W-1:0] want,
	                                      logic [CNT_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// Result monitor. The receiver cannot stall, so every strobed word is
	// taken at the edge that closes its cycle.
	always @(posedge clk) begin : check_words
		arq_word_t want;
		if (arst_n && strobe) begin
			if (words_due.size() == 0) begin
				$display("%0t: unexpected word, expected none, actual kind %0h seq %0h",
				         $time, kind, seq_no);
				mismatches++;
			end else begin
				want = words_due.pop_front();
				compare_field("kind", CNT_W'(want.kind), CNT_W'(kind));
				compare_field("seq_no", CNT_W'(want.seq), CNT_W'(seq_no));
				compare_field("payload", CNT_W'(want.pay), CNT_W'(payload));
				compare_field("is_eof", CNT_W'(want.eof), CNT_W'(is_eof));
				compare_field("window_base", want.base, window_base);
				compare_field("all_done", CNT_W'(want.done), CNT_W'(all_done));
				compare_field("last", CNT_W'(want.last), CNT_W'(last));
			end
		end
	end

	// Straight after reset the default 26-frame, 4-wide window applies. An
	// acknowledge arriving before any start is applied as is: frame 2 is
	// marked, the base stays at 0, and frames 0, 1 and 3 go out.
	task automatic test_ack_before_start();
		issue(OP_LOAD, 8'd0, 8'h00);
		issue(OP_LOAD, 8'd1, 8'hFF);
		issue(OP_LOAD, 8'd2, 8'hA5);
		issue(OP_LOAD, 8'd3, 8'h5A);
		issue(OP_ACK, 8'd2, 8'h00);
	endtask

	// Five frames through a two-wide window: out-of-order acknowledges,
	// a retransmission on timeout, an acknowledge beyond the frame count,
	// the end-of-file frame and completion.
	task automatic test_window_walk();
		write_reg(REG_FRAME_COUNT, 5);
		write_reg(REG_WIN_LEN, 2);
		issue(OP_LOAD, 8'd4, 8'h3C);
		issue(OP_LOAD, 8'd255, 8'h81);
		issue(OP_START, 8'd0, 8'h00);
		issue(OP_ACK, 8'd1, 8'hFF);
		issue(OP_ACK, 8'd0, 8'h00);
		issue(OP_TIMEOUT, 8'hFF, 8'hFF);
		issue(OP_ACK, 8'd255, 8'h00);
		issue(OP_ACK, 8'd3, 8'h00);
		issue(OP_ACK, 8'd2, 8'h00);
		issue(OP_ACK, 8'd4, 8'h00);
		issue(OP_TIMEOUT, 8'd0, 8'h00);
	endtask

	// Frame count dropped below the current base, then a frame count of
	// zero: nothing is transmitted and the transfer reads as done.
	task automatic test_count_edges();
		write_reg(REG_FRAME_COUNT, 3);
		issue(OP_TIMEOUT, 8'd0, 8'h00);
		write_reg(REG_FRAME_COUNT, 0);
		issue(OP_START, 8'd0, 8'h00);
		issue(OP_ACK, 8'd0, 8'h00);
	endtask

	// A window of zero behaves as one, a window above the maximum as the
	// maximum.
	task automatic test_window_clamp();
		write_reg(REG_FRAME_COUNT, 4);
		write_reg(REG_WIN_LEN, 0);
		issue(OP_START, 8'd0, 8'h00);
		write_reg(REG_WIN_LEN, 31);
		issue(OP_TIMEOUT, 8'd0, 8'h00);
	endtask

	// Random traffic under one setting. Most words are acknowledges near the
	// base so the window keeps moving; timeouts, restarts, stray acknowledges,
	// loads and the odd register change are mixed in.
	task automatic test_random_traffic(int idle, int n_items, int count_val, int win_val);
		int                r;
		int                off;
		logic [SEQ_W-1:0]  idx;
		logic [BYTE_W-1:0] data_b;
		int                done_items;
		write_reg(REG_FRAME_COUNT, count_val);
		write_reg(REG_WIN_LEN, win_val);
		idle_pct = idle;
		issue(OP_START, SEQ_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)));
		done_items = 0;
		while (done_items < n_items) begin
			r      = $urandom_range(0, 99);
			idx    = SEQ_W'($urandom_range(0, 255));
			data_b = BYTE_W'($urandom_range(0, 255));
			if (r < 3) begin
				issue(OP_START, idx, data_b);
			end else if (r < 13) begin
				issue(OP_TIMEOUT, idx, data_b);
			end else if (r < 73) begin
				// Reaching past the window lets later acknowledges slide the
				// base across long runs.
				off = $urandom_range(0, 2 * live_window() - 1);
				if (win_base + off < MAX_SEQ)
					idx = SEQ_W'(win_base + off);
				issue(OP_ACK, idx, data_b);
			end else if (r < 83) begin
				issue(OP_ACK, idx, data_b);
			end else if (r < 97) begin
				issue(OP_LOAD, idx, data_b);
			end else begin
				// Register change mid-transfer; not a command word.
				if ($urandom_range(0, 1) == 0)
					write_reg(REG_FRAME_COUNT, $urandom_range(0, 511));
				else
					write_reg(REG_WIN_LEN, $urandom_range(0, 31));
				continue;
			end
			done_items++;
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_ack_before_start();
		test_window_walk();
		test_count_edges();
		test_window_clamp();

		test_random_traffic(0, 60, 12, 3);
		test_random_traffic(59, 60, 40, 16);
		test_random_traffic(26, 30, 1, 1);
		test_random_traffic(0, 80, 256, 31);
		test_random_traffic(59, 50, 7, 0);
		test_random_traffic(26, 80, 511, 8);

		settle();
		// Quiet period to catch any stray word after the last status.
		repeat (300) @(posedge clk);
		if (words_due.size() != 0) begin
			$display("%0t: %0d words expected, actual none arrived", $time, words_due.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("** selective_repeat_sender: PASSED **");
		else
			$display("** selective_repeat_sender: FAILED **");
		$finish;
	end

	// Watchdog: several times the slowest legal run.
	initial begin
		#20_000_000;
		$display("** selective_repeat_sender: FAILED **");
		$finish;
	end

endmodule
